>>> sv/cdd_pkg.sv
package cdd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 12;
    localparam int DN_W    = 20;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 12'd1583;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 12'd2399;

    // floor(y / 100) == (y * RECIP_100) >> RECIP_SHIFT for every 12-bit y
    localparam int PROD_W      = 23;
    localparam int RECIP_SHIFT = 17;
    localparam logic [PROD_W-1:0] RECIP_100 = 23'd1311;
    localparam int QUO_W = PROD_W - RECIP_SHIFT;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // days before month mm of a year that starts in march
    function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mm);
        logic [8:0] ofs;
        case (mm)
            4'd0:    ofs = 9'd0;
            4'd1:    ofs = 9'd31;
            4'd2:    ofs = 9'd61;
            4'd3:    ofs = 9'd92;
            4'd4:    ofs = 9'd122;
            4'd5:    ofs = 9'd153;
            4'd6:    ofs = 9'd184;
            4'd7:    ofs = 9'd214;
            4'd8:    ofs = 9'd245;
            4'd9:    ofs = 9'd275;
            4'd10:   ofs = 9'd306;
            4'd11:   ofs = 9'd337;
            default: ofs = 9'd0;
        endcase
        return ofs;
    endfunction

endpackage

>>> sv/cdd_if.sv
interface cdd_req_if;
    logic                          valid;
    logic                          ready;
    logic [cdd_pkg::DAY_W-1:0]     day_a;
    logic [cdd_pkg::MONTH_W-1:0]   month_a;
    logic [cdd_pkg::YEAR_W-1:0]    year_a;
    logic [cdd_pkg::DAY_W-1:0]     day_b;
    logic [cdd_pkg::MONTH_W-1:0]   month_b;
    logic [cdd_pkg::YEAR_W-1:0]    year_b;

    modport source (output valid, day_a, month_a, year_a, day_b, month_b, year_b,
                    input ready);
    modport sink   (input valid, day_a, month_a, year_a, day_b, month_b, year_b,
                    output ready);
endinterface

interface cdd_rsp_if;
    logic                          valid;
    logic                          ready;
    logic signed [cdd_pkg::DN_W-1:0] day_difference;
    logic                          invalid_date;

    modport source (output valid, day_difference, invalid_date, input ready);
    modport sink   (input valid, day_difference, invalid_date, output ready);
endinterface

>>> sv/calendar_day_difference.sv
// signed day difference between two gregorian dates
// throughput: one request per cycle unless o_rsp stalls, three day-number stages plus the subtract stage
// each stage holds its item until the next one frees, so a stall loses nothing
// reset (synchronous, active low) clears the stage valid bits only
module calendar_day_difference (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cdd_req_if.sink    i_req,
    cdd_rsp_if.source  o_rsp
);

    localparam int NW = cdd_pkg::DN_W;

    logic                r_v1, r_v2, r_v3, r_v4;
    logic                n_en1, n_en2, n_en3, n_en4;
    cdd_pkg::t_stage_en  n_en;

    always_comb begin
        n_en4   = !r_v4 || o_rsp.ready;
        n_en3   = !r_v3 || n_en4;
        n_en2   = !r_v2 || n_en3;
        n_en1   = !r_v1 || n_en2;
        n_en.s1 = n_en1;
        n_en.s2 = n_en2;
        n_en.s3 = n_en3;
    end

    assign i_req.ready = n_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (n_en1) r_v1 <= i_req.valid;
            if (n_en2) r_v2 <= r_v1;
            if (n_en3) r_v3 <= r_v2;
            if (n_en4) r_v4 <= r_v3;
        end
    end

    logic [NW-1:0] w_dn_a, w_dn_b;
    logic          w_ok_a, w_ok_b;

    cdd_day_number u_dn_a (
        .i_clk        (i_clk),
        .i_en         (n_en),
        .i_day        (i_req.day_a),
        .i_month      (i_req.month_a),
        .i_year       (i_req.year_a),
        .o_day_number (w_dn_a),
        .o_ok         (w_ok_a)
    );

    cdd_day_number u_dn_b (
        .i_clk        (i_clk),
        .i_en         (n_en),
        .i_day        (i_req.day_b),
        .i_month      (i_req.month_b),
        .i_year       (i_req.year_b),
        .o_day_number (w_dn_b),
        .o_ok         (w_ok_b)
    );

    // stage 4: subtract, zero on an invalid date
    logic [NW-1:0] r_diff;
    logic          r_invalid;
    logic          n_valid_dates;

    assign n_valid_dates = w_ok_a && w_ok_b;

    always_ff @(posedge i_clk) begin
        if (n_en4) begin
            r_diff    <= n_valid_dates ? (w_dn_a - w_dn_b) : '0;
            r_invalid <= !n_valid_dates;
        end
    end

    assign o_rsp.valid          = r_v4;
    assign o_rsp.day_difference = r_diff;
    assign o_rsp.invalid_date   = r_invalid;

endmodule

>>> sv/cdd_day_number.sv
module cdd_day_number (
    input  logic                          i_clk,
    input  cdd_pkg::t_stage_en            i_en,
    input  logic [cdd_pkg::DAY_W-1:0]     i_day,
    input  logic [cdd_pkg::MONTH_W-1:0]   i_month,
    input  logic [cdd_pkg::YEAR_W-1:0]    i_year,
    output logic [cdd_pkg::DN_W-1:0]      o_day_number,
    output logic                          o_ok
);

    localparam int YW = cdd_pkg::YEAR_W;
    localparam int MW = cdd_pkg::MONTH_W;
    localparam int DW = cdd_pkg::DAY_W;
    localparam int NW = cdd_pkg::DN_W;
    localparam int QW = cdd_pkg::QUO_W;
    localparam int PW = cdd_pkg::PROD_W;

    // stage 1: march-based year and month, quotients by 100
    logic [DW-1:0] r_s1_day;
    logic [MW-1:0] r_s1_month, r_s1_mm;
    logic [YW-1:0] r_s1_year, r_s1_yy;
    logic [QW-1:0] r_s1_q_year, r_s1_q_yy;

    logic          n_early;
    logic [YW-1:0] n_yy;
    logic [MW-1:0] n_mm;
    logic [PW-1:0] n_prod_y, n_prod_yy;

    always_comb begin
        n_early   = (i_month <= cdd_pkg::MONTH_FEB);
        n_yy      = n_early ? i_year - YW'(1) : i_year;
        n_mm      = n_early ? i_month + MW'(9) : i_month - MW'(3);
        n_prod_y  = PW'(i_year) * cdd_pkg::RECIP_100;
        n_prod_yy = PW'(n_yy) * cdd_pkg::RECIP_100;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_day    <= i_day;
            r_s1_month  <= i_month;
            r_s1_year   <= i_year;
            r_s1_yy     <= n_yy;
            r_s1_mm     <= n_mm;
            r_s1_q_year <= n_prod_y[PW-1:cdd_pkg::RECIP_SHIFT];
            r_s1_q_yy   <= n_prod_yy[PW-1:cdd_pkg::RECIP_SHIFT];
        end
    end

    // stage 2: leap year, validity, year and month terms
    logic          r_s2_ok;
    logic [NW-1:0] r_s2_year_term;
    logic [8:0]    r_s2_month_term;
    logic [DW-1:0] r_s2_day;

    logic [YW-1:0] n_rem100;
    logic          n_leap;
    logic          n_ok;
    logic [NW-1:0] n_year_term;

    always_comb begin
        n_rem100 = r_s1_year - YW'(r_s1_q_year) * YW'(100);
        n_leap   = ((r_s1_year[1:0] == 2'd0) && (n_rem100 != '0)) ||
                   ((n_rem100 == '0) && (r_s1_q_year[1:0] == 2'd0));
        n_ok     = (r_s1_month >= cdd_pkg::MONTH_JAN) &&
                   (r_s1_month <= cdd_pkg::MONTH_DEC) &&
                   (r_s1_year >= cdd_pkg::YEAR_MIN) &&
                   (r_s1_year <= cdd_pkg::YEAR_MAX) &&
                   (r_s1_day != '0) &&
                   (r_s1_day <= cdd_pkg::month_len(r_s1_month, n_leap));
        n_year_term = NW'(r_s1_yy) * NW'(365) + NW'(r_s1_yy >> 2)
                    - NW'(r_s1_q_yy) + NW'(r_s1_q_yy >> 2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_ok         <= n_ok;
            r_s2_year_term  <= n_year_term;
            r_s2_month_term <= cdd_pkg::month_offset(r_s1_mm);
            r_s2_day        <= r_s1_day;
        end
    end

    // stage 3: day number
    logic [NW-1:0] r_s3_dn;
    logic          r_s3_ok;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3_dn <= r_s2_year_term + NW'(r_s2_month_term) + NW'(r_s2_day);
            r_s3_ok <= r_s2_ok;
        end
    end

    assign o_day_number = r_s3_dn;
    assign o_ok         = r_s3_ok;

endmodule
